### rtl/assert_macros.svh
// assertion macros shared by the rtl of the plane rescaler
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define TPR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tpr assertion failed");

// next-cycle implication under synchronous active-low reset
`define TPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tpr assertion failed");

`endif

### rtl/tpr_pkg.sv
// types and constants of the timestamp matched plane rescaler
// no dependencies; used by the top level
package tpr_pkg;

    typedef enum logic [1:0] {
        ACT_UPDATE = 2'd0,
        ACT_HEADER = 2'd1,
        ACT_POINT  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    localparam logic [1:0] REG_SPAN  = 2'd0;
    localparam logic [1:0] REG_OFF_X = 2'd1;
    localparam logic [1:0] REG_OFF_Y = 2'd2;
    localparam logic [1:0] REG_OFF_Z = 2'd3;

    localparam logic [31:0] SPAN_RESET = 32'd1000000;
    localparam logic [31:0] SCALE_SAT  = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN    = 32'h8000_0000;
    localparam int          DIV_STEPS  = 48;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_WRITE = 6'b001000,
        ST_HSCAN = 6'b010000,
        ST_DIV   = 6'b100000
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic [47:0]        stamp_us;
        logic signed [31:0] coeff_a;
        logic signed [31:0] coeff_b;
        logic signed [31:0] coeff_c;
        logic signed [31:0] coeff_d;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               out_last;
    } t_out_item;

endpackage

### rtl/tpr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/timestamp_matched_plane_rescaler.sv
// top level of the timestamp matched plane rescaler
// depends on tpr_pkg, tpr_ram and assert_macros.svh
//
// usage
// - input channel (i_in_valid / o_in_stall / i_in) carries floor updates,
//   frame headers and points; output channel (o_out_valid / i_out_stall /
//   o_out) carries one scaled point per point request that has a scale
// - points: pass r_p1v and then the output register to o_out_valid;
//   one point a cycle unless stalled, two-stage multiply and round pipeline
// - floor update: after acceptance, the scan of the plane window through the
//   entry ram read port, the shared multiplier and accumulator, and the
//   write of the new entry
// - frame header: a ram scan, then the bit-serial divider that forms the
//   scale (no divider pass when nothing matches or the divisor is zero)
// - no request is taken while an update or header is in progress
// - reset empties the window (fill count zero), clears the scale and
//   restores the registers to their defaults; no clearing pass is needed
// - a stalled receiver holds the output register; the point pipeline and
//   the input stall with it
// - user must write registers over the apb port only while idle; unenforced
module timestamp_matched_plane_rescaler #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tpr_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tpr_pkg::t_out_item  o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int SW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
    localparam int EW = 80;

    // logical window position to physical slot
    function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
                                              input logic [CW-1:0] lg);
        logic [CW:0] s;
        s = {{(CW + 1 - SW){1'b0}}, base} + {1'b0, lg};
        if (s >= {1'b0, DEPTH_C}) begin
            s = s - {1'b0, DEPTH_C};
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [31:0] sat_66(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sh0_7FFF_FFFF) begin
            r = tpr_pkg::S32_MAX;
        end else if (v < -66'sh0_8000_0000) begin
            r = tpr_pkg::S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // rounded rescale of one coordinate product
    function automatic logic [31:0] round_pt(input logic signed [63:0] p);
        logic signed [65:0] q;
        q = ($signed({{2{p[63]}}, p}) + 66'sd32768) >>> 16;
        return sat_66(q);
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // configuration registers
    logic [31:0] r_span, r_offx, r_offy, r_offz;

    // control and window bookkeeping
    tpr_pkg::t_state r_state;
    logic [CW-1:0]   r_count;
    logic [SW-1:0]   r_oldest;
    logic [CW-1:0]   r_idx;
    logic            r_rv;
    logic [CW-1:0]   r_kept;

    // request in progress
    logic [47:0] r_now;
    logic [31:0] r_ca, r_cb, r_cc, r_cd;

    // moved offset accumulation
    logic [1:0]         r_mi;
    logic signed [63:0] r_prod;
    logic               r_pv;
    logic signed [65:0] r_acc;

    // nearest entry search
    logic        r_found;
    logic [47:0] r_best_dist;
    logic [31:0] r_best_off;

    // bit-serial divider
    logic [47:0] r_dvd;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_dcnt;

    logic [31:0] r_scale;
    logic        r_scale_valid;

    // point pipeline
    logic               r_p1v, r_p1last;
    logic signed [63:0] r_px, r_py, r_pz;
    logic               r_out_valid;
    tpr_pkg::t_out_item r_out;

    // entry ram: stamp in the upper bits, stored offset in the lower
    logic           ram_we;
    logic [SW-1:0]  ram_waddr, ram_raddr;
    logic [EW-1:0]  ram_wdata, ram_rdata;

    tpr_ram #(.WIDTH(EW), .DEPTH(WINDOW_DEPTH)) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic [47:0]        rd_stamp;
    logic [31:0]        rd_off;
    logic               expired;
    logic [47:0]        stamp_gap;
    logic               issue;
    logic               adv, acc;
    logic signed [63:0] mul_res;
    logic signed [65:0] moved;
    logic [31:0]        moved_sat;
    logic [SW-1:0]      new_slot;
    logic [32:0]        rem_sh;
    logic               q_bit;
    logic [31:0]        num_abs, den_abs;

    assign rd_stamp = ram_rdata[79:32];
    assign rd_off   = ram_rdata[31:0];
    assign expired  = ({1'b0, rd_stamp} + {17'd0, r_span}) < {1'b0, r_now};
    assign stamp_gap = (rd_stamp > r_now) ? (rd_stamp - r_now) : (r_now - rd_stamp);
    assign issue    = r_idx < r_count;
    assign ram_raddr = slot_of(r_oldest, r_idx);

    // handshake
    assign adv         = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == tpr_pkg::ST_IDLE) && adv);
    assign acc         = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // shared multiplier for the plane offset transform
    always_comb begin
        unique case (r_mi)
            2'd0:    mul_res = $signed(r_ca) * $signed(r_offx);
            2'd1:    mul_res = $signed(r_cb) * $signed(r_offy);
            default: mul_res = $signed(r_cc) * $signed(r_offz);
        endcase
    end

    // round half up to q16.16, add d, saturate
    assign moved     = ((r_acc + 66'sd32768) >>> 16) + $signed({{34{r_cd[31]}}, r_cd});
    assign moved_sat = sat_66(moved);
    assign new_slot  = (r_kept < DEPTH_C) ? slot_of(r_oldest, r_kept) : r_oldest;

    // ram writes: compaction during the scan, new entry at the end
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot_of(r_oldest, r_kept);
        ram_wdata = ram_rdata;
        if (r_state == tpr_pkg::ST_SCAN) begin
            ram_we = r_rv && !expired;
        end else if (r_state == tpr_pkg::ST_WRITE) begin
            ram_we    = 1'b1;
            ram_waddr = new_slot;
            ram_wdata = {r_now, moved_sat};
        end
    end

    // divider step
    assign rem_sh  = {r_rem[31:0], r_dvd[47]};
    assign q_bit   = rem_sh >= {1'b0, r_den};
    assign num_abs = abs32(r_best_off);
    assign den_abs = abs32(r_cd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tpr_pkg::ST_IDLE;
            r_count       <= '0;
            r_oldest      <= '0;
            r_scale       <= '0;
            r_scale_valid <= 1'b0;
            r_rv          <= 1'b0;
            r_pv          <= 1'b0;
            r_p1v         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_span        <= tpr_pkg::SPAN_RESET;
            r_offx        <= '0;
            r_offy        <= '0;
            r_offz        <= '0;
        end else begin
            // register writes
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    tpr_pkg::REG_SPAN:  r_span <= pwdata;
                    tpr_pkg::REG_OFF_X: r_offx <= pwdata;
                    tpr_pkg::REG_OFF_Y: r_offy <= pwdata;
                    tpr_pkg::REG_OFF_Z: r_offz <= pwdata;
                    default: ;
                endcase
            end

            // point pipeline
            if (adv) begin
                r_p1v       <= acc && (i_in.action == tpr_pkg::ACT_POINT) && r_scale_valid;
                r_out_valid <= r_p1v;
                r_out.out_x    <= round_pt(r_px);
                r_out.out_y    <= round_pt(r_py);
                r_out.out_z    <= round_pt(r_pz);
                r_out.out_last <= r_p1last;
            end
            if (acc) begin
                r_px     <= $signed(i_in.point_x) * $signed({1'b0, r_scale[30:0]});
                r_py     <= $signed(i_in.point_y) * $signed({1'b0, r_scale[30:0]});
                r_pz     <= $signed(i_in.point_z) * $signed({1'b0, r_scale[30:0]});
                r_p1last <= i_in.last_point;
                r_now    <= i_in.stamp_us;
                r_ca     <= i_in.coeff_a;
                r_cb     <= i_in.coeff_b;
                r_cc     <= i_in.coeff_c;
                r_cd     <= i_in.coeff_d;
            end

            unique case (r_state)
                tpr_pkg::ST_IDLE: begin
                    r_idx   <= '0;
                    r_kept  <= '0;
                    r_rv    <= 1'b0;
                    r_found <= 1'b0;
                    r_mi    <= '0;
                    r_pv    <= 1'b0;
                    r_acc   <= '0;
                    if (acc) begin
                        unique case (i_in.action)
                            tpr_pkg::ACT_UPDATE: r_state <= tpr_pkg::ST_SCAN;
                            tpr_pkg::ACT_HEADER: r_state <= tpr_pkg::ST_HSCAN;
                            tpr_pkg::ACT_POINT: begin
                                // end of frame drops the scale
                                if (r_scale_valid && i_in.last_point) begin
                                    r_scale_valid <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                tpr_pkg::ST_SCAN: begin
                    // survivors slide down towards the oldest slot
                    r_rv <= issue;
                    if (issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_rv && !expired) begin
                        r_kept <= r_kept + CW'(1);
                    end
                    if (!issue && !r_rv) begin
                        r_state <= tpr_pkg::ST_MUL;
                    end
                end
                tpr_pkg::ST_MUL: begin
                    if (r_mi != 2'd3) begin
                        r_prod <= mul_res;
                        r_pv   <= 1'b1;
                        r_mi   <= r_mi + 2'd1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        r_acc <= r_acc + {{2{r_prod[63]}}, r_prod};
                    end
                    if (r_mi == 2'd3 && !r_pv) begin
                        r_state <= tpr_pkg::ST_WRITE;
                    end
                end
                tpr_pkg::ST_WRITE: begin
                    if (r_kept < DEPTH_C) begin
                        r_count <= r_kept + CW'(1);
                    end else begin
                        r_count  <= DEPTH_C;
                        r_oldest <= slot_of(r_oldest, CW'(1));
                    end
                    r_state <= tpr_pkg::ST_IDLE;
                end
                tpr_pkg::ST_HSCAN: begin
                    r_rv <= issue;
                    if (issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    // equal stamps skipped, ties keep the older entry
                    if (r_rv && (rd_stamp != r_now)
                        && (!r_found || stamp_gap < r_best_dist)) begin
                        r_found     <= 1'b1;
                        r_best_dist <= stamp_gap;
                        r_best_off  <= rd_off;
                    end
                    if (!issue && !r_rv) begin
                        if (!r_found) begin
                            r_scale_valid <= 1'b0;
                            r_state       <= tpr_pkg::ST_IDLE;
                        end else if (den_abs == 32'd0) begin
                            r_scale       <= tpr_pkg::SCALE_SAT;
                            r_scale_valid <= 1'b1;
                            r_state       <= tpr_pkg::ST_IDLE;
                        end else begin
                            r_dvd   <= {num_abs, 16'd0};
                            r_rem   <= '0;
                            r_den   <= den_abs;
                            r_dcnt  <= '0;
                            r_state <= tpr_pkg::ST_DIV;
                        end
                    end
                end
                tpr_pkg::ST_DIV: begin
                    if (r_dcnt == 6'(tpr_pkg::DIV_STEPS)) begin
                        r_scale <= (|r_dvd[47:31]) ? tpr_pkg::SCALE_SAT
                                                   : {1'b0, r_dvd[30:0]};
                        r_scale_valid <= 1'b1;
                        r_state       <= tpr_pkg::ST_IDLE;
                    end else begin
                        r_rem  <= q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
                        r_dvd  <= {r_dvd[46:0], q_bit};
                        r_dcnt <= r_dcnt + 6'd1;
                    end
                end
                default: r_state <= tpr_pkg::ST_IDLE;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[3:2])
            tpr_pkg::REG_SPAN:  prdata = r_span;
            tpr_pkg::REG_OFF_X: prdata = r_offx;
            tpr_pkg::REG_OFF_Y: prdata = r_offy;
            default:            prdata = r_offz;
        endcase
    end
    assign pready = 1'b1;

`include "assert_macros.svh"

    `TPR_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C)
    `TPR_ASSERT_NOW(a_busy_stalls, i_clk, i_rst_n, r_state != tpr_pkg::ST_IDLE, o_in_stall)
    `TPR_ASSERT_NOW(a_scale_sat, i_clk, i_rst_n, r_scale_valid, !r_scale[31])
    `TPR_ASSERT_NEXT(a_write_done, i_clk, i_rst_n, r_state == tpr_pkg::ST_WRITE,
        r_state == tpr_pkg::ST_IDLE && r_count != '0)

endmodule
